### hdl/pdc_pkg.sv
package pdc_pkg;

	localparam logic [15:0] MAX_PACKET_BYTES = 16'd256;
	localparam logic [15:0] ALL_ONES         = 16'hffff;
	localparam logic [15:0] HEADER_BYTES     = 16'd8;
	localparam logic [15:0] MIN_SIZE         = 16'd10;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_HDR_BAD  = 2'd1,
		ST_LEN_BAD  = 2'd2,
		ST_BODY_BAD = 2'd3
	} status_t;

	typedef enum logic {
		KIND_PAYLOAD = 1'b0,
		KIND_VERDICT = 1'b1
	} kind_t;

	typedef struct packed {
		logic [7:0] byte_value;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  payload_byte;
		logic [15:0] command_code;
		logic [15:0] result_code;
		logic [1:0]  status;
		logic [7:0]  payload_length;
	} out_item_t;

	typedef struct packed {
		logic [15:0] byte_index;
		logic [7:0]  low_byte_hold;
		logic [15:0] header_sum;
		logic [15:0] body_sum;
		logic [15:0] cmd_word;
		logic [15:0] size_word;
		logic [15:0] result_word;
		logic [15:0] header_check_word;
		logic [15:0] footer_word;
	} state_t;

	// ones'-complement add with end-around carry
	function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[15:0] + {15'd0, s[16]};
	endfunction

endpackage

### hdl/pdc_step.sv
module pdc_step (
	input  pdc_pkg::state_t    st,
	input  pdc_pkg::in_item_t  item,
	output pdc_pkg::state_t    st_next,
	output logic               emit,
	output pdc_pkg::out_item_t res
);
	import pdc_pkg::*;

	logic [15:0] idx;
	logic [15:0] size;
	logic [7:0]  b;
	logic        hdr_good;
	logic        size_ok;
	logic [15:0] body_final;
	status_t     status;
	logic [7:0]  plen;
	state_t      upd;

	assign idx  = st.byte_index;
	assign size = st.size_word;
	assign b    = item.byte_value;

	always_comb begin
		upd = st;
		if (idx < HEADER_BYTES) begin
			unique case (idx[2:1])
				2'd0: begin
					if (idx[0]) upd.cmd_word[15:8] = b;
					else upd.cmd_word[7:0] = b;
				end
				2'd1: begin
					if (idx[0]) upd.size_word[15:8] = b;
					else upd.size_word[7:0] = b;
				end
				2'd2: begin
					if (idx[0]) upd.result_word[15:8] = b;
					else upd.result_word[7:0] = b;
				end
				default: begin
					if (idx[0]) upd.header_check_word[15:8] = b;
					else upd.header_check_word[7:0] = b;
				end
			endcase
			if (idx[0]) begin
				unique case (idx[2:1])
					2'd0: upd.header_sum = oc_add(st.header_sum, upd.cmd_word);
					2'd1: upd.header_sum = oc_add(st.header_sum, upd.size_word);
					2'd2: upd.header_sum = oc_add(st.header_sum, upd.result_word);
					default: upd.header_sum = st.header_sum;
				endcase
			end
		end else if (size >= MIN_SIZE) begin
			if (idx < size - 16'd2) begin
				if (!idx[0]) upd.low_byte_hold = b;
				else upd.body_sum = oc_add(st.body_sum, {b, st.low_byte_hold});
			end else if (idx == size - 16'd2) begin
				upd.footer_word[7:0] = b;
			end else if (idx == size - 16'd1) begin
				upd.footer_word[15:8] = b;
			end
		end
		upd.byte_index = (idx != ALL_ONES) ? idx + 16'd1 : ALL_ONES;
	end

	assign hdr_good = (~upd.header_sum) == upd.header_check_word;
	assign size_ok  = (size >= MIN_SIZE) && (size <= MAX_PACKET_BYTES);
	// odd body length: fold the pending byte in as a low byte
	assign body_final = size[0] ? oc_add(upd.body_sum, {8'd0, upd.low_byte_hold})
		: upd.body_sum;

	always_comb begin
		status = ST_OK;
		plen   = 8'd0;
		priority if (idx < 16'd7) begin
			status = ST_LEN_BAD;
		end else if (!hdr_good) begin
			status = ST_HDR_BAD;
		end else if (!size_ok || (idx + 16'd1) != size) begin
			status = ST_LEN_BAD;
		end else begin
			status = ((~body_final) == upd.footer_word) ? ST_OK : ST_BODY_BAD;
			plen   = size[7:0] - 8'd10;
		end
	end

	always_comb begin
		res = '0;
		emit = 1'b0;
		if (item.last_byte) begin
			emit               = 1'b1;
			res.kind           = KIND_VERDICT;
			res.command_code   = upd.cmd_word;
			res.result_code    = upd.result_word;
			res.status         = status;
			res.payload_length = plen;
		end else if (idx >= HEADER_BYTES && size_ok && idx < size - 16'd2 && hdr_good) begin
			emit             = 1'b1;
			res.kind         = KIND_PAYLOAD;
			res.payload_byte = b;
		end
	end

	assign st_next = item.last_byte ? '0 : upd;

endmodule

### hdl/packet_deframer_checksum.sv
// Packet deframer with 16-bit ones'-complement header and body checksums.
// Input channel byte_*: one received byte per transaction, last_byte set on
// the final byte of a packet. Output channel res_*: one transaction per
// payload byte (kind 0) as it arrives while header and size check good, and
// one verdict (kind 1) for the final byte carrying command, result, status
// and payload length. Throughput: one byte per cycle while byte_stall is
// low; the running sums and header capture are updated in the cycle a byte
// is accepted, by one end-around-carry adder per sum.
// Latency: a result is presented on res_valid the cycle after its byte is
// accepted when the output register is free or taken in that cycle.
// Results sit in an output register backed by one skid entry; byte_stall
// rises only while the skid entry is occupied, so a byte is still accepted
// in the cycle the output stalls, and the input then holds until the output
// transaction completes and the skid entry moves into the output register.
// Reset clears all packet state and empties both output entries; a verdict
// also returns the packet state to its reset value for the next packet.
module packet_deframer_checksum (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               byte_valid,
	output logic               byte_stall,
	input  pdc_pkg::in_item_t  byte_data,
	output logic               res_valid,
	input  logic               res_stall,
	output pdc_pkg::out_item_t res_data
);
	import pdc_pkg::*;

	state_t    st_q;
	state_t    st_next;
	logic      emit;
	out_item_t res;
	logic      accept;
	logic      out_valid_q;
	out_item_t out_q;
	logic      skid_valid_q;
	out_item_t skid_q;
	logic      taken;

	pdc_step u_step (
		.st      (st_q),
		.item    (byte_data),
		.st_next (st_next),
		.emit    (emit),
		.res     (res)
	);

	assign byte_stall = skid_valid_q;
	assign accept     = byte_valid && !skid_valid_q;
	assign taken      = out_valid_q && !res_stall;
	assign res_valid  = out_valid_q;
	assign res_data   = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (accept) begin
			st_q <= st_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			priority if (skid_valid_q) begin
				// drain skid into output once the output transaction completes
				if (taken) begin
					skid_valid_q <= 1'b0;
				end
			end else if (accept && emit) begin
				if (out_valid_q && !taken) skid_valid_q <= 1'b1;
				else out_valid_q <= 1'b1;
			end else if (taken) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (taken) out_q <= skid_q;
		end else if (accept && emit) begin
			if (out_valid_q && !taken) skid_q <= res;
			else out_q <= res;
		end
	end

endmodule

### verif/tb_packet_deframer_checksum.sv
`timescale 1ns / 100ps

module tb_packet_deframer_checksum;

	import pdc_pkg::*;

	localparam int QUIET_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 16;
	localparam int PHASE_BYTES  = 360;

	typedef enum int {
		PKT_GOOD,
		PKT_BAD_BODY,
		PKT_BAD_HEADER,
		PKT_SHORT_SIZE,
		PKT_OVERSIZE,
		PKT_TRUNCATED,
		PKT_OVERRUN,
		PKT_NOISE
	} pkt_kind_t;

	// Tracks the deframer state and holds the results each accepted byte should produce.
	class deframe_scoreboard;
		logic [15:0] byte_count;
		logic [7:0]  low_hold;
		logic [15:0] hdr_sum;
		logic [15:0] body_sum;
		logic [15:0] cmd_w;
		logic [15:0] size_w;
		logic [15:0] result_w;
		logic [15:0] hdr_check_w;
		logic [15:0] footer_w;
		out_item_t   expected_q[$];
		int          failures;
		int          bytes_seen;
		int          payload_checked;
		int          verdicts_by_status[4];

		function new();
			failures = 0;
			bytes_seen = 0;
			payload_checked = 0;
			foreach (verdicts_by_status[i]) verdicts_by_status[i] = 0;
			clear_packet();
		endfunction

		static function logic [15:0] ones_add(logic [15:0] a, logic [15:0] b);
			logic [31:0] t;
			t = {16'd0, a} + {16'd0, b};
			t = {16'd0, t[15:0]} + {16'd0, t[31:16]};
			return t[15:0];
		endfunction

		function void clear_packet();
			byte_count = '0;
			low_hold = '0;
			hdr_sum = '0;
			body_sum = '0;
			cmd_w = '0;
			size_w = '0;
			result_w = '0;
			hdr_check_w = '0;
			footer_w = '0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void note_byte(in_item_t item);
			logic [15:0] idx;
			logic [15:0] sz;
			logic [15:0] sum;
			logic [15:0] span;
			logic [7:0]  b;
			logic        hdr_ok;
			int unsigned count;
			out_item_t   r;
			b = item.byte_value;
			idx = byte_count;
			sz = size_w;
			bytes_seen++;
			if (idx < HEADER_BYTES) begin
				case (idx[2:1])
					2'd0: if (idx[0]) cmd_w[15:8] = b; else cmd_w[7:0] = b;
					2'd1: if (idx[0]) size_w[15:8] = b; else size_w[7:0] = b;
					2'd2: if (idx[0]) result_w[15:8] = b; else result_w[7:0] = b;
					default: if (idx[0]) hdr_check_w[15:8] = b; else hdr_check_w[7:0] = b;
				endcase
				if (idx == 16'd1) hdr_sum = ones_add(hdr_sum, cmd_w);
				else if (idx == 16'd3) hdr_sum = ones_add(hdr_sum, size_w);
				else if (idx == 16'd5) hdr_sum = ones_add(hdr_sum, result_w);
			end
			hdr_ok = ((hdr_sum ^ ALL_ONES) == hdr_check_w);
			if (idx >= HEADER_BYTES && sz >= MIN_SIZE) begin
				if (idx < sz - 16'd2) begin
					// body words are little-endian: even offsets hold the low byte
					if (!idx[0]) low_hold = b;
					else body_sum = ones_add(body_sum, {b, low_hold});
					if (!item.last_byte && hdr_ok && sz <= MAX_PACKET_BYTES) begin
						r = '0;
						r.kind = KIND_PAYLOAD;
						r.payload_byte = b;
						expected_q.push_back(r);
					end
				end else if (idx == sz - 16'd2) begin
					footer_w[7:0] = b;
				end else if (idx == sz - 16'd1) begin
					footer_w[15:8] = b;
				end
			end
			if (byte_count != ALL_ONES) byte_count++;
			if (item.last_byte) begin
				count = 32'(idx) + 1;
				r = '0;
				r.kind = KIND_VERDICT;
				r.command_code = cmd_w;
				r.result_code = result_w;
				if (count < HEADER_BYTES) begin
					r.status = ST_LEN_BAD;
				end else if (!hdr_ok) begin
					r.status = ST_HDR_BAD;
				end else if (sz < MIN_SIZE || sz > MAX_PACKET_BYTES || count != sz) begin
					r.status = ST_LEN_BAD;
				end else begin
					sum = body_sum;
					// odd payload: trailing byte counts as a low byte
					if (sz[0]) sum = ones_add(sum, {8'd0, low_hold});
					r.status = ((sum ^ ALL_ONES) == footer_w) ? ST_OK : ST_BODY_BAD;
					span = sz - MIN_SIZE;
					r.payload_length = span[7:0];
				end
				expected_q.push_back(r);
				clear_packet();
			end
		endfunction

		function void check_field(string name, logic [15:0] want, logic [15:0] got);
			if (got !== want) begin
				$error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
				failures++;
			end
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (expected_q.size() == 0) begin
				$error("unexpected result transaction, kind %0d", got.kind);
				failures++;
				return;
			end
			want = expected_q.pop_front();
			check_field("kind", want.kind, got.kind);
			check_field("payload_byte", want.payload_byte, got.payload_byte);
			check_field("command_code", want.command_code, got.command_code);
			check_field("result_code", want.result_code, got.result_code);
			check_field("status", want.status, got.status);
			check_field("payload_length", want.payload_length, got.payload_length);
			if (want.kind == KIND_VERDICT) verdicts_by_status[want.status]++;
			else payload_checked++;
		endfunction

		function void close_out();
			if (expected_q.size() != 0) begin
				$error("%0d expected results never arrived", expected_q.size());
				failures += expected_q.size();
			end
		endfunction
	endclass

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      byte_valid = 1'b0;
	logic      byte_stall;
	in_item_t  byte_data = '0;
	logic      res_valid;
	logic      res_stall = 1'b0;
	out_item_t res_data;

	deframe_scoreboard sb;
	in_item_t          stim_q[$];
	int                send_idle_pct = 0;
	int                recv_stall_pct = 0;
	int                quiet_cycles = 0;

	packet_deframer_checksum DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_data  (byte_data),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res_data   (res_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		res_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (byte_valid && !byte_stall) sb.note_byte(byte_data);
			if (res_valid && !res_stall) sb.check_result(res_data);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (byte_valid && !byte_stall) || (res_valid && !res_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$error("no transaction for %0d cycles", QUIET_LIMIT);
			$display("Some tests failed");
			$finish;
		end
	end

	// Build one packet of the given flavor and append its bytes to the stimulus.
	task automatic queue_packet(input pkt_kind_t kind, input int unsigned size_req);
		logic [7:0]  pkt[$];
		logic [15:0] cmd;
		logic [15:0] res;
		logic [15:0] sz;
		logic [15:0] chk;
		logic [15:0] bsum;
		logic [15:0] foot;
		logic [7:0]  b;
		logic [7:0]  lo;
		in_item_t    item;
		cmd = 16'($urandom);
		res = 16'($urandom);
		sz = 16'(size_req);
		if (kind == PKT_SHORT_SIZE)
			sz = 16'($urandom_range(0, 9));
		else if (kind == PKT_OVERSIZE)
			sz = ($urandom_range(3) == 0) ? 16'($urandom_range(301, 65535))
				: 16'($urandom_range(257, 300));
		chk = deframe_scoreboard::ones_add(deframe_scoreboard::ones_add(cmd, sz), res)
			^ ALL_ONES;
		if (kind == PKT_BAD_HEADER) chk = chk ^ 16'($urandom_range(1, 65535));
		pkt.push_back(cmd[7:0]);
		pkt.push_back(cmd[15:8]);
		pkt.push_back(sz[7:0]);
		pkt.push_back(sz[15:8]);
		pkt.push_back(res[7:0]);
		pkt.push_back(res[15:8]);
		pkt.push_back(chk[7:0]);
		pkt.push_back(chk[15:8]);
		if (sz >= MIN_SIZE && sz <= 16'd300) begin
			bsum = '0;
			lo = '0;
			for (int i = 0; i < int'(sz) - 10; i++) begin
				b = 8'($urandom);
				pkt.push_back(b);
				if (i % 2 == 0) lo = b;
				else bsum = deframe_scoreboard::ones_add(bsum, {b, lo});
			end
			if (sz[0]) bsum = deframe_scoreboard::ones_add(bsum, {8'd0, lo});
			foot = bsum ^ ALL_ONES;
			if (kind == PKT_BAD_BODY) foot = foot ^ 16'($urandom_range(1, 65535));
			pkt.push_back(foot[7:0]);
			pkt.push_back(foot[15:8]);
		end else begin
			repeat ($urandom_range(0, 12)) pkt.push_back(8'($urandom));
		end
		if (kind == PKT_TRUNCATED) begin
			repeat ($urandom_range(1, pkt.size() - 1)) void'(pkt.pop_back());
		end else if (kind == PKT_OVERRUN) begin
			repeat ($urandom_range(1, 4)) pkt.push_back(8'($urandom));
		end else if (kind == PKT_NOISE) begin
			pkt.delete();
			repeat ($urandom_range(1, 30)) pkt.push_back(8'($urandom));
		end
		foreach (pkt[i]) begin
			item.byte_value = pkt[i];
			item.last_byte = (i == pkt.size() - 1);
			stim_q.push_back(item);
		end
	endtask

	task automatic drive_bytes();
		in_item_t item;
		while (stim_q.size() != 0) begin
			item = stim_q.pop_front();
			while ($urandom_range(99) < send_idle_pct) begin
				byte_valid <= 1'b0;
				@(posedge clk);
			end
			byte_valid <= 1'b1;
			byte_data <= item;
			@(posedge clk);
			// hold the transaction until it is taken
			while (byte_stall) @(posedge clk);
		end
	endtask

	initial begin
		pkt_kind_t   kind;
		int unsigned r;
		int unsigned size_req;
		in_item_t    item;
		sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty payload, odd single-byte payload, then tiny runts
		queue_packet(PKT_GOOD, MIN_SIZE);
		queue_packet(PKT_GOOD, 11);
		item.byte_value = 8'hff;
		item.last_byte = 1'b1;
		stim_q.push_back(item);
		item.byte_value = 8'h00;
		item.last_byte = 1'b0;
		stim_q.push_back(item);
		item.byte_value = 8'hff;
		stim_q.push_back(item);
		item.byte_value = 8'h00;
		item.last_byte = 1'b1;
		stim_q.push_back(item);
		drive_bytes();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
				default: begin send_idle_pct = 9; recv_stall_pct = 9; end
			endcase
			while (stim_q.size() < PHASE_BYTES) begin
				r = $urandom_range(99);
				kind = (r < 60) ? PKT_GOOD : (r < 68) ? PKT_BAD_BODY :
					(r < 75) ? PKT_BAD_HEADER : (r < 80) ? PKT_SHORT_SIZE :
					(r < 85) ? PKT_OVERSIZE : (r < 91) ? PKT_TRUNCATED :
					(r < 96) ? PKT_OVERRUN : PKT_NOISE;
				r = $urandom_range(99);
				if (r < 3) size_req = MAX_PACKET_BYTES;
				else if (r < 8) size_req = MIN_SIZE;
				else if (r < 12) size_req = $urandom_range(41, 255);
				else size_req = $urandom_range(11, 40);
				queue_packet(kind, size_req);
			end
			drive_bytes();
		end
		byte_valid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		sb.close_out();

		$display("Fed %0d bytes through four handshake mixes; %0d payload bytes checked.",
			sb.bytes_seen, sb.payload_checked);
		$display("Verdicts: %0d ok, %0d header bad, %0d length bad, %0d body bad.",
			sb.verdicts_by_status[ST_OK], sb.verdicts_by_status[ST_HDR_BAD],
			sb.verdicts_by_status[ST_LEN_BAD], sb.verdicts_by_status[ST_BODY_BAD]);
		if (sb.failures == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

### filelist.f
hdl/pdc_pkg.sv
hdl/pdc_step.sv
hdl/packet_deframer_checksum.sv
verif/tb_packet_deframer_checksum.sv
